/* src/rbd_pkg.sv */
// ---------------------------------------------------------------------------
// rbd_pkg: shared types and codes of the ring buffer deque
// Request kinds, result status codes, field widths and the command and
// status bundles that pass between controller and datapath.
// ---------------------------------------------------------------------------
package rbd_pkg;

    // Field widths fixed by the interface
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;
    localparam int COUNT_W  = 5;
    // Working width for head plus count sums before wrapping
    localparam int WORK_W   = 6;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_HEAD  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_TAIL  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;    // latch request, load head into work register
        logic reduce;    // subtract capacity from work register
        logic head_set;  // take wrapped work value as head
        logic check;     // latch done, full or empty status
        logic slot_set;  // load tail slot sum into work register
        logic access;    // touch the store, update head and count
        logic out_load;  // load the result register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic work_ge_cap; // work register not yet wrapped
        logic fault;       // push into full or pop from empty
        logic tail_end;    // request works at the tail
        logic out_free;    // result register can take a new result
    } t_dp_sts;

endpackage

/* src/rbd_ram.sv */
// ---------------------------------------------------------------------------
// rbd_ram: generic single-port RAM
// One write or one read per cycle; read data is registered and holds
// until the next read.
// ---------------------------------------------------------------------------
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                      i_wdata,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rbd_ctrl.sv */
// ---------------------------------------------------------------------------
// rbd_ctrl: request sequencer of the ring buffer deque
// Steps one request through head wrap, status check, slot wrap (tail end
// only), store access and result hand-off; a fault skips to the hand-off.
// ---------------------------------------------------------------------------
module rbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  rbd_pkg::t_dp_sts i_sts,
    output rbd_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_PREP,
        S_SLOT,
        S_ACCESS,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_sts.work_ge_cap) begin
                    o_cmd.reduce = 1'b1;
                end else begin
                    o_cmd.head_set = 1'b1;
                    n_state        = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.check = 1'b1;
                if (i_sts.fault) begin
                    n_state = S_FINISH;
                end else if (i_sts.tail_end) begin
                    o_cmd.slot_set = 1'b1;
                    n_state        = S_SLOT;
                end else begin
                    n_state = S_ACCESS;
                end
            end
            S_SLOT: begin
                if (i_sts.work_ge_cap) begin
                    o_cmd.reduce = 1'b1;
                end else begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                o_cmd.access = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

/* src/rbd_dp.sv */
// ---------------------------------------------------------------------------
// rbd_dp: datapath of the ring buffer deque
// Head index, entry count, capacity register, wrap arithmetic, item store
// and the result register.
// ---------------------------------------------------------------------------
module rbd_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [rbd_pkg::CAP_W-1:0]     i_cfg_capacity,
    input  logic [rbd_pkg::KIND_W-1:0]    i_kind,
    input  logic [DATA_WIDTH-1:0]         i_data_in,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic [rbd_pkg::STATUS_W-1:0]  o_status,
    output logic [DATA_WIDTH-1:0]         o_data_out,
    output logic [rbd_pkg::COUNT_W-1:0]   o_count,
    input  rbd_pkg::t_dp_cmd              i_cmd,
    output rbd_pkg::t_dp_sts              o_sts
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_RESET_INT = (16 > DEPTH) ? DEPTH : 16;
    localparam logic [rbd_pkg::CAP_W-1:0] CAP_RESET = rbd_pkg::CAP_W'(CAP_RESET_INT);
    localparam logic [rbd_pkg::CAP_W-1:0] CAP_MAX   = rbd_pkg::CAP_W'(DEPTH);

    logic [AW-1:0]                    r_head;
    logic [rbd_pkg::COUNT_W-1:0]      r_count;
    logic [rbd_pkg::CAP_W-1:0]        r_cap;
    logic [rbd_pkg::WORK_W-1:0]       r_work;
    logic [rbd_pkg::KIND_W-1:0]       r_kind;
    logic [DATA_WIDTH-1:0]            r_data;
    logic [rbd_pkg::STATUS_W-1:0]     r_status;
    logic                             r_rsp_valid;
    logic [rbd_pkg::STATUS_W-1:0]     r_rsp_status;
    logic [DATA_WIDTH-1:0]            r_rsp_data;
    logic [rbd_pkg::COUNT_W-1:0]      r_rsp_count;

    logic [rbd_pkg::CAP_W-1:0]        cfg_eff;
    logic [rbd_pkg::WORK_W-1:0]       cap_w;
    logic [rbd_pkg::WORK_W-1:0]       head_w;
    logic [rbd_pkg::WORK_W-1:0]       count_w;
    logic [rbd_pkg::WORK_W-1:0]       head_dec;
    logic [rbd_pkg::WORK_W-1:0]       head_inc;
    logic [rbd_pkg::WORK_W-1:0]       slot_w;
    logic                             is_push;
    logic                             fault;
    logic                             ram_we;
    logic                             ram_re;
    logic [DATA_WIDTH-1:0]            ram_rdata;

    // Clamp written capacity to 1..DEPTH
    always_comb begin
        if (i_cfg_capacity == '0) begin
            cfg_eff = rbd_pkg::CAP_W'(1);
        end else if (32'(i_cfg_capacity) > 32'(DEPTH)) begin
            cfg_eff = CAP_MAX;
        end else begin
            cfg_eff = i_cfg_capacity;
        end
    end

    assign cap_w   = rbd_pkg::WORK_W'(r_cap);
    assign head_w  = rbd_pkg::WORK_W'(r_head);
    assign count_w = rbd_pkg::WORK_W'(r_count);
    assign is_push = (r_kind == rbd_pkg::KIND_PUSH_TAIL) || (r_kind == rbd_pkg::KIND_PUSH_HEAD);
    assign fault   = is_push ? (count_w >= cap_w) : (r_count == '0);

    // Step head back or forward with wrap at the capacity
    assign head_dec = (head_w == '0) ? (cap_w - 1'b1) : (head_w - 1'b1);
    assign head_inc = ((head_w + 1'b1) == cap_w) ? '0 : (head_w + 1'b1);

    // Pick the store slot of this request
    always_comb begin
        unique case (r_kind)
            rbd_pkg::KIND_PUSH_HEAD: slot_w = head_dec;
            rbd_pkg::KIND_POP_HEAD:  slot_w = head_w;
            default:                 slot_w = r_work;
        endcase
    end

    assign ram_we = i_cmd.access && is_push;
    assign ram_re = i_cmd.access && !is_push;

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (AW'(slot_w)),
        .i_wdata (r_data),
        .o_rdata (ram_rdata)
    );

    // Control registers: head, count, capacity, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= cfg_eff;
            end
            if (i_cmd.head_set) begin
                r_head <= AW'(r_work);
            end
            if (i_cmd.access) begin
                if (is_push) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                end
                if (r_kind == rbd_pkg::KIND_PUSH_HEAD) begin
                    r_head <= AW'(head_dec);
                end else if (r_kind == rbd_pkg::KIND_POP_HEAD) begin
                    r_head <= AW'(head_inc);
                end
            end
            if (i_cmd.out_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload registers: request, wrap work value, status, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_data <= i_data_in;
            r_work <= head_w;
        end else if (i_cmd.reduce) begin
            r_work <= r_work - cap_w;
        end else if (i_cmd.slot_set) begin
            if (r_kind == rbd_pkg::KIND_PUSH_TAIL) begin
                r_work <= head_w + count_w;
            end else begin
                r_work <= head_w + count_w - 1'b1;
            end
        end
        if (i_cmd.check) begin
            if (!fault) begin
                r_status <= rbd_pkg::STATUS_DONE;
            end else if (is_push) begin
                r_status <= rbd_pkg::STATUS_FULL;
            end else begin
                r_status <= rbd_pkg::STATUS_EMPTY;
            end
        end
        if (i_cmd.out_load) begin
            r_rsp_status <= r_status;
            r_rsp_count  <= r_count;
            if (r_status == rbd_pkg::STATUS_DONE && !is_push) begin
                r_rsp_data <= ram_rdata;
            end else begin
                r_rsp_data <= '0;
            end
        end
    end

    assign o_sts.work_ge_cap = (r_work >= cap_w);
    assign o_sts.fault       = fault;
    assign o_sts.tail_end    = (r_kind == rbd_pkg::KIND_PUSH_TAIL) ||
                               (r_kind == rbd_pkg::KIND_POP_TAIL);
    assign o_sts.out_free    = !r_rsp_valid || i_rsp_ready;

    assign o_rsp_valid = r_rsp_valid;
    assign o_status    = r_rsp_status;
    assign o_data_out  = r_rsp_data;
    assign o_count     = r_rsp_count;

endmodule

/* src/ring_buffer_deque.sv */
// ---------------------------------------------------------------------------
// ring_buffer_deque: double-ended queue in a ring store
// Push or pop at either end of a queue held in a single-port RAM.
// ---------------------------------------------------------------------------
// Each request (push tail, push head, pop head, pop tail) gives one result
// carrying a status, the popped item and the entry count after the request.
// One request is in work at a time: a new request is accepted only after the
// last one has loaded its result. Head-end requests skip the slot wrap; a
// push into a full queue or a pop from an empty one skips it and the store
// access. The head and the tail slot wrap by the shared compare-subtract
// step, and each subtraction of the capacity lengthens the request. With the
// store read registered, the store access and the result load take separate
// steps for pushes and pops alike. A finished result waits in its own
// register, so the next request is taken while the result is still unread; if
// that result is still unread when the next one is done, the next one holds in
// its last step until the first is taken. The capacity register is to be
// written by the user through its own port only while the queue is idle; the
// block does not enforce this. Values are clamped to 1..DEPTH.
// ---------------------------------------------------------------------------
module ring_buffer_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // capacity write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rbd_pkg::CAP_W-1:0]     i_cfg_capacity,
    // request
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [rbd_pkg::KIND_W-1:0]    i_kind,
    input  logic [DATA_WIDTH-1:0]         i_data_in,
    // result
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output logic [rbd_pkg::STATUS_W-1:0]  o_status,
    output logic [DATA_WIDTH-1:0]         o_data_out,
    output logic [rbd_pkg::COUNT_W-1:0]   o_count
);

    rbd_pkg::t_dp_cmd cmd;
    rbd_pkg::t_dp_sts sts;

    // Capacity writes are always taken
    assign o_cfg_ready = 1'b1;

    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rbd_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_capacity (i_cfg_capacity),
        .i_kind         (i_kind),
        .i_data_in      (i_data_in),
        .i_rsp_ready    (i_rsp_ready),
        .o_rsp_valid    (o_rsp_valid),
        .o_status       (o_status),
        .o_data_out     (o_data_out),
        .o_count        (o_count),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule
